// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define BLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define BLS_ASSERT_NEVER(label, expr, msg) \
  `BLS_ASSERT(label, !(expr), msg)

`endif

// ===== src/bls_pkg.sv =====
`timescale 1ns / 1ps

package bls_pkg;

  localparam int COORD_BITS  = 15;
  localparam int SPAN_X_BITS = COORD_BITS + 1;
  localparam int SPAN_Y_BITS = COORD_BITS + 2;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int DBL_BITS    = ERR_BITS + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [SPAN_X_BITS-1:0] diff_t;
  typedef logic        [SPAN_X_BITS-1:0] span_x_t;
  typedef logic signed [SPAN_Y_BITS-1:0] span_y_t;
  typedef logic signed [ERR_BITS-1:0]    err_t;
  typedef logic signed [DBL_BITS-1:0]    dbl_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // One classified transaction as it sits in the queue
  typedef struct packed {
    cmd_t    cmd;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
    logic    pen_black;
    span_x_t span_x;
    span_y_t span_y_neg;
    logic    dir_x_neg;
    logic    dir_y_neg;
    logic    at_goal;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== src/bls_front.sv =====
`timescale 1ns / 1ps

module bls_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  bls_pkg::coord_t    x_start,
  input  bls_pkg::coord_t    y_start,
  input  bls_pkg::coord_t    x_end,
  input  bls_pkg::coord_t    y_end,
  input  logic               pen_black,
  input  bls_pkg::queue_stat_t q_stat,
  output logic               push,
  output bls_pkg::job_t      push_job
);
  import bls_pkg::*;

  logic  held;
  job_t  job;
  job_t  job_next;
  diff_t dx_fwd, dx_rev, dy_fwd, dy_rev;
  logic  x_lt, y_lt;

  // start set-up: both signed differences in parallel, pick by direction
  always_comb begin
    dx_fwd = diff_t'(x_end) - diff_t'(x_start);
    dx_rev = diff_t'(x_start) - diff_t'(x_end);
    dy_fwd = diff_t'(y_end) - diff_t'(y_start);
    dy_rev = diff_t'(y_start) - diff_t'(y_end);
    x_lt   = x_start < x_end;
    y_lt   = y_start < y_end;

    job_next.cmd        = cmd_t'(cmd);
    job_next.x_start    = x_start;
    job_next.y_start    = y_start;
    job_next.x_end      = x_end;
    job_next.y_end      = y_end;
    job_next.pen_black  = pen_black;
    job_next.span_x     = span_x_t'(x_lt ? dx_fwd : dx_rev);
    job_next.span_y_neg = span_y_t'(y_lt ? dy_rev : dy_fwd);
    job_next.dir_x_neg  = !x_lt;
    job_next.dir_y_neg  = !y_lt;
    job_next.at_goal    = (x_start == x_end) && (y_start == y_end);
  end

  assign push     = held && !q_stat.full;
  assign in_stall = held && q_stat.full;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      job <= job_next;
    end
  end

endmodule

// ===== src/bls_queue.sv =====
`timescale 1ns / 1ps

module bls_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bls_pkg::job_t        push_job,
  input  logic                 pop,
  output bls_pkg::job_t        head_job,
  output bls_pkg::queue_stat_t q_stat
);
  import bls_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push, do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/bls_back.sv =====
`timescale 1ns / 1ps

module bls_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bls_pkg::job_t        head_job,
  input  bls_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bls_pkg::coord_t      pixel_x,
  output bls_pkg::coord_t      pixel_y,
  output logic                 ink,
  output logic                 last_pixel
);
  import bls_pkg::*;

  coord_t  cur_x, cur_y, goal_x, goal_y;
  logic    dir_x_neg, dir_y_neg;
  span_x_t span_x;
  span_y_t span_y_neg;
  err_t    err_acc;
  logic    busy;
  logic    held_ink;

  logic    adv;
  logic    is_start;
  logic    emits;
  dbl_t    dbl, sx_dbl, sy_dbl;
  logic    move_x, move_y;
  err_t    err_step, err_init;
  coord_t  x_step, y_step;
  logic    step_last;

  assign adv      = !out_valid || !out_stall;
  assign pop      = !q_stat.empty && adv;
  assign is_start = (head_job.cmd == CMD_START);
  assign emits    = is_start || busy;

  // one Bresenham step: doubled error against both spans
  always_comb begin
    dbl      = $signed({err_acc, 1'b0});
    sx_dbl   = $signed({{(DBL_BITS - SPAN_X_BITS){1'b0}}, span_x});
    sy_dbl   = dbl_t'(span_y_neg);
    move_x   = dbl >= sy_dbl;
    move_y   = dbl <= sx_dbl;
    err_step = err_acc
             + (move_x ? err_t'(span_y_neg) : '0)
             + (move_y ? $signed({{(ERR_BITS - SPAN_X_BITS){1'b0}}, span_x}) : '0);
    x_step   = cur_x;
    y_step   = cur_y;
    if (move_x) begin
      x_step = dir_x_neg ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
    end
    if (move_y) begin
      y_step = dir_y_neg ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
    end
    step_last = (x_step == goal_x) && (y_step == goal_y);
    err_init  = $signed({{(ERR_BITS - SPAN_X_BITS){1'b0}}, head_job.span_x})
              + err_t'(head_job.span_y_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= pop && emits;
      end
      if (pop) begin
        if (is_start) begin
          busy <= !head_job.at_goal;
        end else if (busy) begin
          busy <= !step_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_start) begin
        cur_x      <= head_job.x_start;
        cur_y      <= head_job.y_start;
        goal_x     <= head_job.x_end;
        goal_y     <= head_job.y_end;
        dir_x_neg  <= head_job.dir_x_neg;
        dir_y_neg  <= head_job.dir_y_neg;
        span_x     <= head_job.span_x;
        span_y_neg <= head_job.span_y_neg;
        err_acc    <= err_init;
        held_ink   <= head_job.pen_black;
        pixel_x    <= head_job.x_start;
        pixel_y    <= head_job.y_start;
        ink        <= head_job.pen_black;
        last_pixel <= head_job.at_goal;
      end else if (busy) begin
        cur_x      <= x_step;
        cur_y      <= y_step;
        err_acc    <= err_step;
        pixel_x    <= x_step;
        pixel_y    <= y_step;
        ink        <= held_ink;
        last_pixel <= step_last;
      end
    end
  end

endmodule

// ===== src/bresenham_line_stepper.sv =====
// Bresenham line stepper. A start transaction (cmd 0) loads both endpoints
// and the ink colour and yields the start pixel; each step transaction
// (cmd 1) yields the next pixel of the line, the end point flagged with
// last_pixel, after which the engine is idle and further steps yield
// nothing. A start while a line is running abandons it. Sustained rate is
// one transaction per clock while out_stall is low, so one pixel per clock
// on a running line; the figure is set by the stepping unit, whose
// doubled-error compare and error update are combinational. A transaction
// passes through the front register (which works out spans and directions
// for starts), then a slot of the two-entry queue, into the output
// register. The queue lets the front keep taking transactions while a
// finished pixel waits on out_stall.
`timescale 1ns / 1ps

module bresenham_line_stepper (
  input  logic            clk,
  input  logic            rst,
  // command channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            cmd,
  input  bls_pkg::coord_t x_start,
  input  bls_pkg::coord_t y_start,
  input  bls_pkg::coord_t x_end,
  input  bls_pkg::coord_t y_end,
  input  logic            pen_black,
  // pixel channel
  output logic            out_valid,
  input  logic            out_stall,
  output bls_pkg::coord_t pixel_x,
  output bls_pkg::coord_t pixel_y,
  output logic            ink,
  output logic            last_pixel
);
  import bls_pkg::*;

  queue_stat_t q_stat;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head_job;

  // front: takes transactions, classifies, prepares start set-up
  bls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .pen_black (pen_black),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // short queue decoupling front from stepper
  bls_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // back: line state, error stepping, output register
  bls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .ink        (ink),
    .last_pixel (last_pixel)
  );

endmodule

// ===== src/bls_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bls_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input bls_pkg::coord_t pixel_x,
  input bls_pkg::coord_t pixel_y,
  input logic            ink,
  input logic            last_pixel
);

  // held pixel must not move while stalled
  `BLS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({pixel_x, pixel_y, ink, last_pixel}), "pixel changed under stall")

  // queue only fills behind a stalled pixel
  `BLS_ASSERT_NEVER(a_stall_without_out, in_valid && in_stall && !out_valid, "input stalled with no pixel waiting")

  // pipeline is empty straight after reset
  `BLS_ASSERT(a_flush_after_reset, $past(rst) || $past(rst, 2) |-> !out_valid, "pixel too soon after reset")

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (.*);

// ===== tb/tb_bresenham_line_stepper.sv =====
`timescale 1ns / 1ps

module tb_bresenham_line_stepper;
  import bls_pkg::*;

  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int ITEM_TARGET = 1650;
  // ~2k transactions; this is many times over
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  // output register sits behind the front register and the queue
  localparam int TAIL_CYCLES = 10;

  // one command transaction as queued for the driver
  typedef struct {
    cmd_t   op;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    logic   pen;
  } stroke_cmd_t;

  // one pixel as it should leave the block
  typedef struct {
    coord_t x;
    coord_t y;
    logic   ink;
    logic   last;
  } pixel_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  logic   cmd       = CMD_STEP;
  coord_t x_start   = '0;
  coord_t y_start   = '0;
  coord_t x_end     = '0;
  coord_t y_end     = '0;
  logic   pen_black = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   ink;
  logic   last_pixel;

  stroke_cmd_t cmd_queue[$];
  pixel_t      pending_pixels[$];

  int   cycle_count = 0;
  int   faults      = 0;
  int   taken       = 0;
  // set for a stretch of the run: neither side idles then
  logic calm        = 1'b0;

  bresenham_line_stepper dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .pen_black  (pen_black),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .ink        (ink),
    .last_pixel (last_pixel)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------
  // Line tracer: own copy of the stepping engine's state
  // ---------------------------------------------------------------------
  coord_t   at_x     = '0;
  coord_t   at_y     = '0;
  coord_t   to_x     = '0;
  coord_t   to_y     = '0;
  logic     back_x   = 1'b0;  // x walks downwards
  logic     back_y   = 1'b0;  // y walks downwards
  span_x_t  run_x    = '0;    // |dx|
  span_y_t  rise_neg = '0;    // -|dy|
  err_t     err      = '0;
  logic     drawing  = 1'b0;
  logic     colour   = 1'b0;

  // Works out the pixel (if any) caused by one accepted transaction
  task automatic trace_pixel(input stroke_cmd_t c);
    int     ddx;
    int     ddy;
    dbl_t   twice;
    pixel_t p;
    if (c.op == CMD_START) begin
      // a start always restarts, even over a running line
      at_x   = c.xs;
      at_y   = c.ys;
      to_x   = c.xe;
      to_y   = c.ye;
      colour = c.pen;
      ddx    = int'(c.xe) - int'(c.xs);
      ddy    = int'(c.ye) - int'(c.ys);
      run_x    = span_x_t'(ddx < 0 ? -ddx : ddx);
      rise_neg = span_y_t'(ddy < 0 ? ddy : -ddy);
      back_x   = !(c.xs < c.xe);
      back_y   = !(c.ys < c.ye);
      err      = err_t'(int'(run_x) + int'(rise_neg));
    end else if (!drawing) begin
      // step with no line running: nothing comes out
      return;
    end else begin
      // both tests use the doubled error from before either update
      twice = {err, 1'b0};
      if (twice >= dbl_t'(rise_neg)) begin
        err  = err + err_t'(rise_neg);
        at_x = back_x ? at_x - coord_t'(1) : at_x + coord_t'(1);
      end
      if (twice <= dbl_t'($signed({1'b0, run_x}))) begin
        err  = err + err_t'($signed({1'b0, run_x}));
        at_y = back_y ? at_y - coord_t'(1) : at_y + coord_t'(1);
      end
    end
    p.x     = at_x;
    p.y     = at_y;
    p.ink   = colour;
    p.last  = (at_x == to_x) && (at_y == to_y);
    drawing = !p.last;
    pending_pixels.push_back(p);
  endtask

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  task automatic push_start(input int xs, input int ys, input int xe, input int ye,
                            input logic pen);
    stroke_cmd_t c;
    c.op  = CMD_START;
    c.xs  = coord_t'(xs);
    c.ys  = coord_t'(ys);
    c.xe  = coord_t'(xe);
    c.ye  = coord_t'(ye);
    c.pen = pen;
    cmd_queue.push_back(c);
  endtask

  // step transactions carry random payload, which the block must ignore
  task automatic push_steps(input int n);
    stroke_cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.op  = CMD_STEP;
      c.xs  = any_coord();
      c.ys  = any_coord();
      c.xe  = any_coord();
      c.ye  = any_coord();
      c.pen = 1'($urandom);
      cmd_queue.push_back(c);
    end
  endtask

  // A short line anywhere on the plane, mostly walked to its end (with up to
  // two spare steps), sometimes cut short by the next start.
  task automatic add_random_line(output int counted);
    int xs;
    int ys;
    int xe;
    int ye;
    int dx;
    int dy;
    int reach;
    int span;
    int n;
    xs    = int'(any_coord());
    ys    = int'(any_coord());
    reach = ($urandom_range(9) == 0) ? 60 : 10;
    dx    = int'($urandom_range(2 * reach)) - reach;
    dy    = int'($urandom_range(2 * reach)) - reach;
    case ($urandom_range(7))
      0: dx = 0;
      1: dy = 0;
      2: dy = $urandom_range(1) ? dx : -dx;
      default: ;
    endcase
    xe = xs + dx;
    if (xe > COORD_MAX || xe < COORD_MIN) xe = xs - dx;
    ye = ys + dy;
    if (ye > COORD_MAX || ye < COORD_MIN) ye = ys - dy;
    span = (dx < 0 ? -dx : dx);
    if ((dy < 0 ? -dy : dy) > span) span = (dy < 0 ? -dy : dy);
    if ($urandom_range(9) < 7 || span == 0) begin
      n = span + $urandom_range(2);
    end else begin
      n = $urandom_range(span - 1);
    end
    push_start(xs, ys, xe, ye, 1'($urandom));
    push_steps(n);
    // transactions queued: the start plus every step
    counted = 1 + n;
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued transactions, idling at random
  // ---------------------------------------------------------------------
  stroke_cmd_t on_wire;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        trace_pixel(on_wire);
        taken++;
      end
      calm <= (taken >= 700) && (taken < 1000);
      // payload only moves once the held transaction has gone
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          on_wire = cmd_queue.pop_front();
          in_valid  <= 1'b1;
          cmd       <= on_wire.op;
          x_start   <= on_wire.xs;
          y_start   <= on_wire.ys;
          x_end     <= on_wire.xe;
          y_end     <= on_wire.ye;
          pen_black <= on_wire.pen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: takes pixels, holds them back at random, checks each one
  // ---------------------------------------------------------------------
  pixel_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          note_fault($sformatf("unexpected pixel (%0d,%0d) ink %0b last %0b",
                               pixel_x, pixel_y, ink, last_pixel));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_x !== want.x || pixel_y !== want.y || ink !== want.ink ||
              last_pixel !== want.last) begin
            note_fault($sformatf(
              "pixel mismatch: expected (%0d,%0d) ink %0b last %0b, got (%0d,%0d) ink %0b last %0b",
              want.x, want.y, want.ink, want.last, pixel_x, pixel_y, ink, last_pixel));
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sequence: directed lines, then random ones, then drain
  // ---------------------------------------------------------------------
  initial begin
    int queued;
    int got;
    int roll;
    queued = 0;

    // step with nothing running
    push_steps(1);
    // single-point line, then a step that must yield nothing
    push_start(5, 5, 5, 5, 1'b1);
    push_steps(1);
    // corner-to-corner lines at the coordinate extremes, each abandoned
    // by the next start after a step or two
    push_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    push_steps(2);
    push_start(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
    push_steps(1);
    push_start(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    push_steps(1);
    // shallow line walking down in y, one spare step at the end
    push_start(0, 0, 3, -2, 1'b0);
    push_steps(4);
    // steep line walking back in x, one spare step at the end
    push_start(2, 1, -1, 7, 1'b1);
    push_steps(7);

    while (queued < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        add_random_line(got);
        queued += got;
      end else if (roll < 92) begin
        // far-flung endpoints, only the first few pixels taken
        got = $urandom_range(3);
        push_start(int'(any_coord()), int'(any_coord()), int'(any_coord()),
                   int'(any_coord()), 1'($urandom));
        push_steps(got);
        queued += 1 + got;
      end else begin
        push_steps(1);
        queued += 1;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
